// ----- rtl/core/pid_filtered_derivative_controller_assert.svh -----
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent assertion forms shared by the controller's RTL.
// ----------------------------------------------------------------------------
`ifndef PID_FILTERED_DERIVATIVE_CONTROLLER_ASSERT_SVH
`define PID_FILTERED_DERIVATIVE_CONTROLLER_ASSERT_SVH

// The condition in one cycle requires the expression in the next cycle.
`define PFD_ASSERT_NEXT(label, clk_sig, rst_sig, cond, expr, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (cond) |=> (expr)) else $error(msg);

// The condition requires the expression in the same cycle.
`define PFD_ASSERT_NOW(label, clk_sig, rst_sig, cond, expr, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (cond) |-> (expr)) else $error(msg);

`endif

// ----- rtl/core/pfd_pkg.sv -----
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, register indexes, configuration type and saturation helpers.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int DATA_W           = 32;
    localparam int WIDE_W           = 64;
    localparam int CFG_IDX_W        = 4;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_FRAC_BITS    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KP               = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_FEEDBACK   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW_LIMIT    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH_LIMIT   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOW_LIMIT  = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_HIGH_LIMIT = CFG_IDX_W'(7);

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam word_t S32_MAX = 32'sh7fff_ffff;
    localparam word_t S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        word_t kp;
        word_t integ_gain;
        word_t deriv_gain;
        word_t deriv_feedback;
        word_t out_low_limit;
        word_t out_high_limit;
        word_t integ_low_limit;
        word_t integ_high_limit;
    } cfg_t;

    function automatic word_t sat32(input wide_t x);
        word_t r;
        if (x > WIDE_W'(S32_MAX))
        begin
            r = S32_MAX;
        end
        else if (x < WIDE_W'(S32_MIN))
        begin
            r = S32_MIN;
        end
        else
        begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

    // When the limits cross, a value above the high limit gets the high limit and any other value gets the low limit.
    function automatic word_t clamp32(input word_t x, input word_t lo, input word_t hi);
        word_t r;
        if (x > hi)
        begin
            r = hi;
        end
        else if (x < lo)
        begin
            r = lo;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/pfd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// PID controller configuration channel
// Register write requests: index and data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfd_cfg_if import pfd_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// ----- rtl/core/pfd_feed_if.sv -----
// ----------------------------------------------------------------------------
// PID controller sample channel
// Setpoint and measurement requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfd_feed_if import pfd_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) ();

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] target;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output target, output sample, input ready);
    modport sink   (input valid, input target, input sample, output ready);

endinterface

// ----- rtl/core/pfd_drive_if.sv -----
// ----------------------------------------------------------------------------
// PID controller drive channel
// Clamped drive requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfd_drive_if import pfd_pkg::*; ();

    logic  valid;
    logic  ready;
    word_t drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);

endinterface

// ----- rtl/core/pfd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// PID controller configuration registers
// Holds the gains and limits written over the configuration channel.
// ----------------------------------------------------------------------------
module pfd_cfg_regs import pfd_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    pfd_cfg_if.sink cfg,
    output cfg_t   regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KP:               regs_next.kp               = cfg.data;
                REG_INTEG_GAIN:       regs_next.integ_gain       = cfg.data;
                REG_DERIV_GAIN:       regs_next.deriv_gain       = cfg.data;
                REG_DERIV_FEEDBACK:   regs_next.deriv_feedback   = cfg.data;
                REG_OUT_LOW_LIMIT:    regs_next.out_low_limit    = cfg.data;
                REG_OUT_HIGH_LIMIT:   regs_next.out_high_limit   = cfg.data;
                REG_INTEG_LOW_LIMIT:  regs_next.integ_low_limit  = cfg.data;
                REG_INTEG_HIGH_LIMIT: regs_next.integ_high_limit = cfg.data;
                default:              regs_next                  = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '{kp:               '0,
                          integ_gain:       '0,
                          deriv_gain:       '0,
                          deriv_feedback:   '0,
                          out_low_limit:    S32_MIN,
                          out_high_limit:   S32_MAX,
                          integ_low_limit:  S32_MIN,
                          integ_high_limit: S32_MAX};
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- rtl/core/pfd_front.sv -----
// ----------------------------------------------------------------------------
// PID controller front stage
// Input register, error and the three gain products that need no feedback.
// ----------------------------------------------------------------------------
module pfd_front import pfd_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    localparam int ERR_W  = SAMPLE_WIDTH + 1,
    localparam int ESUM_W = SAMPLE_WIDTH + 2,
    localparam int PP_W   = DATA_W + ERR_W,
    localparam int IG_W   = DATA_W + ESUM_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           regs,
    input  logic                           load,
    input  logic signed [SAMPLE_WIDTH-1:0] target,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           advance,
    output word_t                          p_term,
    output logic signed [IG_W-1:0]         ig_prod,
    output logic signed [PP_W-1:0]         dg_prod
);

    logic signed [SAMPLE_WIDTH-1:0] tgt_reg;
    logic signed [SAMPLE_WIDTH-1:0] smp_reg;
    logic signed [ERR_W-1:0]        last_error_reg;
    logic signed [ERR_W-1:0]        last_error_next;
    logic signed [SAMPLE_WIDTH-1:0] last_sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] last_sample_next;
    logic signed [ERR_W-1:0]        err;
    logic signed [ESUM_W-1:0]       err_sum;
    logic signed [ERR_W-1:0]        smp_diff;
    logic signed [PP_W-1:0]         p_full;
    word_t                          p_term_reg;
    word_t                          p_term_next;
    logic signed [IG_W-1:0]         ig_prod_reg;
    logic signed [IG_W-1:0]         ig_prod_next;
    logic signed [PP_W-1:0]         dg_prod_reg;
    logic signed [PP_W-1:0]         dg_prod_next;

    always_comb
    begin
        err          = ERR_W'(tgt_reg) - ERR_W'(smp_reg);
        err_sum      = ESUM_W'(err) + ESUM_W'(last_error_reg);
        smp_diff     = ERR_W'(smp_reg) - ERR_W'(last_sample_reg);
        p_full       = PP_W'(regs.kp) * PP_W'(err);
        p_term_next  = sat32(WIDE_W'(p_full));
        ig_prod_next = IG_W'(regs.integ_gain) * IG_W'(err_sum);
        dg_prod_next = PP_W'(regs.deriv_gain) * PP_W'(smp_diff);
        last_error_next  = advance ? err : last_error_reg;
        last_sample_next = advance ? smp_reg : last_sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg  <= '0;
            last_sample_reg <= '0;
        end
        else
        begin
            last_error_reg  <= last_error_next;
            last_sample_reg <= last_sample_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tgt_reg <= target;
            smp_reg <= sample;
        end
        if (advance)
        begin
            p_term_reg  <= p_term_next;
            ig_prod_reg <= ig_prod_next;
            dg_prod_reg <= dg_prod_next;
        end
    end

    assign p_term  = p_term_reg;
    assign ig_prod = ig_prod_reg;
    assign dg_prod = dg_prod_reg;

endmodule

// ----- rtl/core/pfd_core.sv -----
// ----------------------------------------------------------------------------
// PID controller state stage
// Clamped trapezoidal integrator and band-limited derivative feedback.
// ----------------------------------------------------------------------------
module pfd_core import pfd_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = DEF_FRAC_BITS,
    localparam int IG_W = DATA_W + SAMPLE_WIDTH + 2,
    localparam int DG_W = DATA_W + SAMPLE_WIDTH + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   regs,
    input  logic                   advance,
    input  word_t                  p_term,
    input  logic signed [IG_W-1:0] ig_prod,
    input  logic signed [DG_W-1:0] dg_prod,
    output word_t                  p_out,
    output word_t                  integ_acc,
    output word_t                  deriv_acc
);

    localparam wide_t ROUND = wide_t'(1) <<< (FRAC_BITS - 1);

    word_t integ_acc_reg;
    word_t integ_acc_next;
    word_t deriv_acc_reg;
    word_t deriv_acc_next;
    word_t p_out_reg;
    wide_t integ_sum;
    wide_t fb_prod;
    wide_t fb;
    wide_t deriv_sum;

    always_comb
    begin
        integ_sum = WIDE_W'(integ_acc_reg) + WIDE_W'(ig_prod);
        fb_prod   = WIDE_W'(regs.deriv_feedback) * WIDE_W'(deriv_acc_reg);
        fb        = (fb_prod + ROUND) >>> FRAC_BITS;
        deriv_sum = WIDE_W'(dg_prod) + fb;
        integ_acc_next = integ_acc_reg;
        deriv_acc_next = deriv_acc_reg;
        if (advance)
        begin
            integ_acc_next = clamp32(sat32(integ_sum), regs.integ_low_limit,
                                     regs.integ_high_limit);
            deriv_acc_next = sat32(-deriv_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_acc_reg <= '0;
            deriv_acc_reg <= '0;
        end
        else
        begin
            integ_acc_reg <= integ_acc_next;
            deriv_acc_reg <= deriv_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_out_reg <= p_term;
        end
    end

    assign p_out     = p_out_reg;
    assign integ_acc = integ_acc_reg;
    assign deriv_acc = deriv_acc_reg;

endmodule

// ----- rtl/core/pfd_out.sv -----
// ----------------------------------------------------------------------------
// PID controller output stage
// Sums the three terms, saturates, clamps and registers the drive value.
// ----------------------------------------------------------------------------
module pfd_out import pfd_pkg::*; (
    input  logic  clk,
    input  cfg_t  regs,
    input  logic  advance,
    input  word_t p_term,
    input  word_t integ_acc,
    input  word_t deriv_acc,
    output word_t drive
);

    logic signed [DATA_W+1:0] term_sum;
    word_t                    drive_reg;
    word_t                    drive_next;

    always_comb
    begin
        term_sum   = (DATA_W+2)'(p_term) + (DATA_W+2)'(integ_acc)
                   + (DATA_W+2)'(deriv_acc);
        drive_next = clamp32(sat32(WIDE_W'(term_sum)), regs.out_low_limit,
                             regs.out_high_limit);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

// ----- rtl/core/pid_filtered_derivative_controller.sv -----
// ----------------------------------------------------------------------------
// PID controller with filtered derivative
// Trapezoidal integrator with anti-windup clamp, band-limited derivative on
// the measurement, and a clamped Q16.16 drive output.
// ----------------------------------------------------------------------------
// Usage:
// The feed channel takes one request per sample, carrying a target and a
// sample; each request gives exactly one drive request on the result channel.
// Gains and limits are written on the cfg channel, which is always ready, and
// should only be written while no sample is in flight.
// The pipeline has four registered stages: input, gain products, integrator
// and derivative state, and the output sum. A sample passes through them in
// that order before its drive value is offered on the result channel; a new
// sample can be accepted every cycle unless a receiver stall backs them up.
// The derivative loop in the state stage holds one 32 by 32 multiply.
// Reset clears the accumulators, the previous error and sample, the gains to
// zero, and opens every limit to the full 32-bit range.
// When the receiver stalls, the waiting drive value holds and the earlier
// stages keep filling until each holds a sample; then feed.ready drops.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_controller import pfd_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    pfd_cfg_if.sink      cfg,
    pfd_feed_if.sink     feed,
    pfd_drive_if.source  result
);

    localparam int IG_W = DATA_W + SAMPLE_WIDTH + 2;
    localparam int DG_W = DATA_W + SAMPLE_WIDTH + 1;

    cfg_t                   regs;
    logic                   v0_reg;
    logic                   v0_next;
    logic                   v1_reg;
    logic                   v1_next;
    logic                   v2_reg;
    logic                   v2_next;
    logic                   v3_reg;
    logic                   v3_next;
    logic                   room0;
    logic                   room1;
    logic                   room2;
    logic                   room3;
    logic                   move0;
    logic                   move1;
    logic                   move2;
    logic                   accept;
    word_t                  p_term;
    logic signed [IG_W-1:0] ig_prod;
    logic signed [DG_W-1:0] dg_prod;
    word_t                  p_state;
    word_t                  integ_acc;
    word_t                  deriv_acc;
    word_t                  drive;

    always_comb
    begin
        room3   = !v3_reg || result.ready;
        move2   = v2_reg && room3;
        room2   = !v2_reg || move2;
        move1   = v1_reg && room2;
        room1   = !v1_reg || move1;
        move0   = v0_reg && room1;
        room0   = !v0_reg || move0;
        accept  = feed.valid && room0;
        v0_next = accept || (v0_reg && !move0);
        v1_next = move0 || (v1_reg && !move1);
        v2_next = move1 || (v2_reg && !move2);
        v3_next = move2 || (v3_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign feed.ready   = room0;
    assign result.valid = v3_reg;
    assign result.drive = drive;

    pfd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pfd_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (regs),
        .load    (accept),
        .target  (feed.target),
        .sample  (feed.sample),
        .advance (move0),
        .p_term  (p_term),
        .ig_prod (ig_prod),
        .dg_prod (dg_prod)
    );

    pfd_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .advance   (move1),
        .p_term    (p_term),
        .ig_prod   (ig_prod),
        .dg_prod   (dg_prod),
        .p_out     (p_state),
        .integ_acc (integ_acc),
        .deriv_acc (deriv_acc)
    );

    pfd_out u_out (
        .clk       (clk),
        .regs      (regs),
        .advance   (move2),
        .p_term    (p_state),
        .integ_acc (integ_acc),
        .deriv_acc (deriv_acc),
        .drive     (drive)
    );

`include "pid_filtered_derivative_controller_assert.svh"

    `PFD_ASSERT_NEXT(a_accept_fills_input, clk, rst_n, feed.valid && feed.ready, v0_reg,
        "accepted sample did not reach the input stage")
    `PFD_ASSERT_NEXT(a_input_moves_on, clk, rst_n, move0, v1_reg,
        "sample left the input stage but the product stage is empty")
    `PFD_ASSERT_NEXT(a_state_moves_on, clk, rst_n, move2, v3_reg,
        "sample left the state stage but no drive value is offered")
    `PFD_ASSERT_NOW(a_empty_input_ready, clk, rst_n, !v0_reg, feed.ready,
        "empty input stage refused a sample")

endmodule

// ----- verif/pid_filtered_derivative_controller_tb.sv -----
// ----------------------------------------------------------------------------
// PID controller regression bench
// Drives setpoint and measurement requests through the controller, with
// register writes between phases. A bit-exact model of the control law
// predicts every drive request, and each arriving drive request is checked
// in order. Directed cases cover saturation, crossed limits and ignored
// register indexes. One long receiver stall then backs up the pipeline, and a
// long randomized run follows, with random gaps on both channels in most phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pid_filtered_derivative_controller_tb import pfd_pkg::*;;

    localparam int SW            = DEF_SAMPLE_WIDTH;
    localparam int FRAC          = DEF_FRAC_BITS;
    localparam int LATENCY       = 3;
    localparam int SETTLE_CYCLES = LATENCY + 3;
    localparam int LONG_HOLD     = 150;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 100;
    localparam int REG_COUNT     = int'(REG_INTEG_HIGH_LIMIT) + 1;
    localparam int REG_LAST_IDX  = (1 << CFG_IDX_W) - 1;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    localparam word_t ONE_Q = 32'sh0001_0000;

    typedef logic signed [SW-1:0] sample_t;
    typedef logic signed [SW:0]   error_t;

    logic clk;
    logic rst_n;

    pfd_cfg_if                       cfg_ch ();
    pfd_feed_if #(.SAMPLE_WIDTH(SW)) feed_ch ();
    pfd_drive_if                     drive_ch ();

    pid_filtered_derivative_controller #(
        .SAMPLE_WIDTH (SW),
        .FRAC_BITS    (FRAC)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .feed   (feed_ch),
        .result (drive_ch)
    );

    word_t   k_prop;
    word_t   k_integ;
    word_t   k_deriv;
    word_t   k_fback;
    word_t   drive_lo;
    word_t   drive_hi;
    word_t   integ_lo;
    word_t   integ_hi;

    word_t   integ_state;
    word_t   deriv_state;
    error_t  err_prev;
    sample_t sample_prev;

    word_t   expected_drive[$];
    word_t   drive_want;
    int      mismatches;

    bit      feed_gaps;
    bit      sink_gaps;
    bit      long_hold_request;

    sample_t walk_sample;
    sample_t setpoint;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic word_t clip_word(input longint x);
        word_t r;
        if (x > WORD_MAX)
        begin
            r = word_t'(WORD_MAX);
        end
        else if (x < WORD_MIN)
        begin
            r = word_t'(WORD_MIN);
        end
        else
        begin
            r = word_t'(x);
        end
        return r;
    endfunction

    function automatic word_t limit_word(input word_t x, input word_t lo, input word_t hi);
        word_t r;
        if (x > hi)
        begin
            r = hi;
        end
        else if (x < lo)
        begin
            r = lo;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

    function automatic void clear_controller_model();
        k_prop      = '0;
        k_integ     = '0;
        k_deriv     = '0;
        k_fback     = '0;
        drive_lo    = word_t'(WORD_MIN);
        drive_hi    = word_t'(WORD_MAX);
        integ_lo    = word_t'(WORD_MIN);
        integ_hi    = word_t'(WORD_MAX);
        integ_state = '0;
        deriv_state = '0;
        err_prev    = '0;
        sample_prev = '0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx, input word_t value);
        case (idx)
            REG_KP:               k_prop   = value;
            REG_INTEG_GAIN:       k_integ  = value;
            REG_DERIV_GAIN:       k_deriv  = value;
            REG_DERIV_FEEDBACK:   k_fback  = value;
            REG_OUT_LOW_LIMIT:    drive_lo = value;
            REG_OUT_HIGH_LIMIT:   drive_hi = value;
            REG_INTEG_LOW_LIMIT:  integ_lo = value;
            REG_INTEG_HIGH_LIMIT: integ_hi = value;
            default:              ;
        endcase
    endfunction

    // Advances the controller state by one sample and returns its drive value.
    function automatic word_t next_drive(input sample_t tgt, input sample_t smp);
        longint err;
        longint prop;
        longint fb;
        longint d;
        word_t  total;
        err  = longint'(tgt) - longint'(smp);
        prop = longint'(clip_word(longint'(k_prop) * err));
        integ_state = limit_word(
            clip_word(longint'(integ_state) + longint'(k_integ) * (err + longint'(err_prev))),
            integ_lo, integ_hi);
        fb = (longint'(k_fback) * longint'(deriv_state) + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        d  = longint'(k_deriv) * (longint'(smp) - longint'(sample_prev)) + fb;
        deriv_state = clip_word(-d);
        total = clip_word(prop + longint'(integ_state) + longint'(deriv_state));
        err_prev    = error_t'(err);
        sample_prev = smp;
        return limit_word(total, drive_lo, drive_hi);
    endfunction

    function automatic word_t draw_coef(input int bits);
        word_t r;
        case ($urandom_range(0, 15))
            0:       r = word_t'(WORD_MAX);
            1:       r = word_t'(WORD_MIN);
            2:       r = word_t'($urandom);
            3:       r = '0;
            default: r = word_t'(int'($urandom_range(0, 2 ** (bits + 1))) - 2 ** bits);
        endcase
        return r;
    endfunction

    task automatic draw_limits(output word_t lo, output word_t hi, input int bits);
        word_t a;
        word_t b;
        int    pick;
        a    = word_t'(int'($urandom_range(0, 2 ** (bits + 1))) - 2 ** bits);
        b    = word_t'(int'($urandom_range(0, 2 ** (bits + 1))) - 2 ** bits);
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            lo = word_t'(WORD_MIN);
            hi = word_t'(WORD_MAX);
        end
        else if ((pick == 1) == (a < b))
        begin
            lo = b;
            hi = a;
        end
        else
        begin
            lo = a;
            hi = b;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        feed_ch.valid <= 1'b0;
        while (expected_drive.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        apply_register(idx, value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_sample(input sample_t tgt, input sample_t smp);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            feed_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        feed_ch.valid  <= 1'b1;
        feed_ch.target <= tgt;
        feed_ch.sample <= smp;
        do
            @(posedge clk);
        while (feed_ch.ready !== 1'b1);
        expected_drive.push_back(next_drive(tgt, smp));
    endtask

    task automatic configure_all(input word_t kp_v, input word_t ig_v, input word_t dg_v,
                                 input word_t fb_v, input word_t olo, input word_t ohi,
                                 input word_t ilo, input word_t ihi);
        wait_drained();
        write_reg(REG_KP, kp_v);
        write_reg(REG_INTEG_GAIN, ig_v);
        write_reg(REG_DERIV_GAIN, dg_v);
        write_reg(REG_DERIV_FEEDBACK, fb_v);
        write_reg(REG_OUT_LOW_LIMIT, olo);
        write_reg(REG_OUT_HIGH_LIMIT, ohi);
        write_reg(REG_INTEG_LOW_LIMIT, ilo);
        write_reg(REG_INTEG_HIGH_LIMIT, ihi);
    endtask

    task automatic configure_random();
        word_t olo;
        word_t ohi;
        word_t ilo;
        word_t ihi;
        word_t fb_v;
        draw_limits(olo, ohi, 28);
        draw_limits(ilo, ihi, 26);
        if ($urandom_range(0, 3) == 0)
        begin
            fb_v = draw_coef(20);
        end
        else
        begin
            fb_v = word_t'($urandom_range(0, 65535));
        end
        configure_all(draw_coef(18), draw_coef(10), draw_coef(16), fb_v, olo, ohi, ilo, ihi);
    endtask

    task automatic test_reset_defaults();
        send_sample(sample_t'(32767), sample_t'(-32768));
        send_sample(sample_t'(-32768), sample_t'(32767));
        send_sample(sample_t'(0), sample_t'(0));
        wait_drained();
    endtask

    task automatic test_proportional();
        wait_drained();
        write_reg(REG_KP, word_t'(WORD_MAX));
        send_sample(sample_t'(32767), sample_t'(-32768));
        send_sample(sample_t'(-32768), sample_t'(32767));
        wait_drained();
        write_reg(REG_KP, word_t'(WORD_MIN));
        send_sample(sample_t'(1), sample_t'(0));
        wait_drained();
        write_reg(REG_KP, ONE_Q);
        send_sample(sample_t'(100), sample_t'(40));
        wait_drained();
    endtask

    task automatic test_integrator();
        wait_drained();
        write_reg(REG_KP, '0);
        write_reg(REG_INTEG_GAIN, 32'sh0000_8000);
        write_reg(REG_INTEG_LOW_LIMIT, -32'sh0010_0000);
        write_reg(REG_INTEG_HIGH_LIMIT, 32'sh0010_0000);
        send_sample(sample_t'(1000), sample_t'(0));
        send_sample(sample_t'(1000), sample_t'(0));
        wait_drained();
        write_reg(REG_INTEG_LOW_LIMIT, 32'sh0005_0000);
        write_reg(REG_INTEG_HIGH_LIMIT, -32'sh0005_0000);
        send_sample(sample_t'(5), sample_t'(0));
        send_sample(sample_t'(-5), sample_t'(0));
        wait_drained();
        write_reg(REG_INTEG_GAIN, word_t'(WORD_MAX));
        write_reg(REG_INTEG_LOW_LIMIT, word_t'(WORD_MIN));
        write_reg(REG_INTEG_HIGH_LIMIT, word_t'(WORD_MAX));
        send_sample(sample_t'(32767), sample_t'(-32768));
        wait_drained();
        write_reg(REG_INTEG_GAIN, '0);
    endtask

    task automatic test_derivative();
        wait_drained();
        write_reg(REG_DERIV_GAIN, ONE_Q);
        write_reg(REG_DERIV_FEEDBACK, 32'sh0000_8000);
        send_sample(sample_t'(0), sample_t'(100));
        send_sample(sample_t'(0), sample_t'(100));
        send_sample(sample_t'(0), sample_t'(-32768));
        wait_drained();
        write_reg(REG_DERIV_FEEDBACK, word_t'(WORD_MAX));
        send_sample(sample_t'(0), sample_t'(-32768));
        wait_drained();
        write_reg(REG_DERIV_FEEDBACK, word_t'(WORD_MIN));
        send_sample(sample_t'(0), sample_t'(32767));
        wait_drained();
    endtask

    task automatic test_output_clamp();
        configure_all(ONE_Q, '0, '0, '0, -32'sh0032_0000, 32'sh0032_0000,
                      word_t'(WORD_MIN), word_t'(WORD_MAX));
        send_sample(sample_t'(100), sample_t'(0));
        send_sample(sample_t'(-100), sample_t'(0));
        wait_drained();
        write_reg(REG_OUT_LOW_LIMIT, ONE_Q);
        write_reg(REG_OUT_HIGH_LIMIT, -ONE_Q);
        send_sample(sample_t'(0), sample_t'(0));
        send_sample(sample_t'(5), sample_t'(0));
        wait_drained();
    endtask

    // Writes to indexes past the last register must leave every gain untouched.
    task automatic test_unused_index();
        wait_drained();
        write_reg(CFG_IDX_W'(REG_COUNT), word_t'(WORD_MAX));
        write_reg(CFG_IDX_W'(REG_LAST_IDX), word_t'(WORD_MIN));
        write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, REG_LAST_IDX)), word_t'($urandom));
        send_sample(sample_t'(7), sample_t'(-3));
        wait_drained();
    endtask

    task automatic test_backpressure();
        configure_random();
        feed_gaps = 1'b0;
        long_hold_request = 1'b1;
        repeat (40)
        begin
            send_sample(sample_t'($urandom), sample_t'($urandom));
        end
        wait_drained();
        feed_gaps = 1'b1;
    endtask

    task automatic send_random_item();
        sample_t tgt;
        sample_t smp;
        int      v;
        case ($urandom_range(0, 7))
            0:
            begin
                tgt = sample_t'($urandom);
                smp = sample_t'($urandom);
            end
            1:
            begin
                setpoint = sample_t'($urandom);
                tgt = setpoint;
                smp = walk_sample;
            end
            default:
            begin
                v = int'(walk_sample) + int'($urandom_range(0, 128)) - 64;
                if (v > 32767)
                begin
                    v = 32767;
                end
                else if (v < -32768)
                begin
                    v = -32768;
                end
                walk_sample = sample_t'(v);
                tgt = setpoint;
                smp = walk_sample;
            end
        endcase
        send_sample(tgt, smp);
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                configure_all(word_t'(WORD_MAX), word_t'(WORD_MIN), word_t'(WORD_MAX),
                              word_t'(WORD_MIN), word_t'(WORD_MIN), word_t'(WORD_MAX),
                              word_t'(WORD_MIN), word_t'(WORD_MAX));
            end
            else if (phase == 1)
            begin
                configure_all(word_t'(WORD_MIN), word_t'(WORD_MAX), word_t'(WORD_MIN),
                              word_t'(WORD_MAX), -ONE_Q, ONE_Q, -ONE_Q, ONE_Q);
            end
            else
            begin
                configure_random();
            end
            feed_gaps = (phase % 4 != 3);
            sink_gaps = (phase % 4 != 3);
            repeat (PHASE_ITEMS)
            begin
                send_random_item();
            end
        end
        feed_gaps = 1'b1;
        sink_gaps = 1'b1;
        wait_drained();
    endtask

    initial
    begin : drive_sink
        int stall;
        forever
        begin
            if (long_hold_request)
            begin
                stall = LONG_HOLD;
                long_hold_request = 1'b0;
            end
            else
            begin
                stall = sink_gaps ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                drive_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            drive_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rst_n === 1'b1 && drive_ch.valid === 1'b1));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && drive_ch.valid === 1'b1 && drive_ch.ready === 1'b1)
        begin
            if (expected_drive.size() == 0)
            begin
                $error("drive: no request expected, actual %0d", drive_ch.drive);
                mismatches++;
            end
            else
            begin
                drive_want = expected_drive.pop_front();
                if (drive_ch.drive !== drive_want)
                begin
                    $error("drive: expected %0d, actual %0d", drive_want, drive_ch.drive);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        feed_ch.valid     = 1'b0;
        feed_ch.target    = '0;
        feed_ch.sample    = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        drive_ch.ready    = 1'b0;
        feed_gaps         = 1'b1;
        sink_gaps         = 1'b1;
        long_hold_request = 1'b0;
        mismatches        = 0;
        walk_sample       = '0;
        setpoint          = '0;
        clear_controller_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_proportional();
        test_integrator();
        test_derivative();
        test_output_clamp();
        test_unused_index();
        test_backpressure();
        test_random_phases();

        wait_drained();
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
